// ----- sv/scfr_pkg.sv -----
// ----------------------------------------------------------------------------
// scfr_pkg
// Types, constants and the CRC8 step shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package scfr_pkg;

	// receive buffer limit: a length byte L with L + 4 >= BUFFER_BYTES is rejected
	localparam int unsigned BUFFER_BYTES = 40;
	localparam logic [7:0]  CRC_INIT     = 8'hFF;
	localparam logic [5:0]  HEADER_BYTES = 6'd2;
	localparam logic [8:0]  LEN_SLACK    = 9'(2 * HEADER_BYTES);
	localparam logic [8:0]  LEN_LIMIT    = 9'(BUFFER_BYTES);

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_WAITING  = 3'd1,
		EV_READY    = 3'd2,
		EV_BAD_CRC  = 3'd3,
		EV_COMPLETE = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		REG_CRC_POLY     = 3'd0,
		REG_CODE_BOOT    = 3'd1,
		REG_CODE_ERASE   = 3'd2,
		REG_CODE_WRITE   = 3'd3,
		REG_CODE_GETPAGE = 3'd4,
		REG_CODE_PROBE   = 3'd5,
		REG_CODE_LOADER  = 3'd6
	} reg_idx_t;

	localparam logic [7:0] RST_CRC_POLY     = 8'h31;
	localparam logic [7:0] RST_CODE_BOOT    = 8'h10;
	localparam logic [7:0] RST_CODE_ERASE   = 8'h11;
	localparam logic [7:0] RST_CODE_WRITE   = 8'h12;
	localparam logic [7:0] RST_CODE_GETPAGE = 8'h13;
	localparam logic [7:0] RST_CODE_PROBE   = 8'h14;
	localparam logic [7:0] RST_CODE_LOADER  = 8'h15;

	typedef struct packed {
		logic [7:0] crc_poly;
		logic [7:0] code_boot;
		logic [7:0] code_erase;
		logic [7:0] code_write;
		logic [7:0] code_get_page;
		logic [7:0] code_probe;
		logic [7:0] code_enter_loader;
	} cfg_t;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		event_t     event_res;
		logic [7:0] frame_type;
		logic [7:0] frame_length;
		logic       payload_valid;
		logic [5:0] payload_index;
		logic [7:0] payload_byte;
	} result_t;

	// msb-first crc8 over one byte, eight shift steps
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- sv/scfr_ifs.sv -----
// ----------------------------------------------------------------------------
// scfr channel interfaces
// Valid/ready channels for received words, results and register writes.
// ----------------------------------------------------------------------------
interface scfr_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;
	modport source(output valid, output op, output rx_byte, input ready);
	modport sink(input valid, input op, input rx_byte, output ready);
endinterface

interface scfr_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [7:0] frame_type;
	logic [7:0] frame_length;
	logic       payload_valid;
	logic [5:0] payload_index;
	logic [7:0] payload_byte;
	modport source(output valid, output event_res, output frame_type, output frame_length,
		output payload_valid, output payload_index, output payload_byte, input ready);
	modport sink(input valid, input event_res, input frame_type, input frame_length,
		input payload_valid, input payload_index, input payload_byte, output ready);
endinterface

interface scfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- sv/scfr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// scfr_cfg_regs
// Polynomial and command code registers, written by index.
// ----------------------------------------------------------------------------
module scfr_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [2:0]    index,
	input  logic [7:0]    data,
	output scfr_pkg::cfg_t cfg
);
	import scfr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_poly          <= RST_CRC_POLY;
			cfg_q.code_boot         <= RST_CODE_BOOT;
			cfg_q.code_erase        <= RST_CODE_ERASE;
			cfg_q.code_write        <= RST_CODE_WRITE;
			cfg_q.code_get_page     <= RST_CODE_GETPAGE;
			cfg_q.code_probe        <= RST_CODE_PROBE;
			cfg_q.code_enter_loader <= RST_CODE_LOADER;
		end else if (we) begin
			// writes past the last register are dropped
			unique case (index)
				REG_CRC_POLY:     cfg_q.crc_poly          <= data;
				REG_CODE_BOOT:    cfg_q.code_boot         <= data;
				REG_CODE_ERASE:   cfg_q.code_erase        <= data;
				REG_CODE_WRITE:   cfg_q.code_write        <= data;
				REG_CODE_GETPAGE: cfg_q.code_get_page     <= data;
				REG_CODE_PROBE:   cfg_q.code_probe        <= data;
				REG_CODE_LOADER:  cfg_q.code_enter_loader <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/scfr_frame_fsm.sv -----
// ----------------------------------------------------------------------------
// scfr_frame_fsm
// Frame parser state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module scfr_frame_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  scfr_pkg::in_item_t item,
	input  scfr_pkg::cfg_t    cfg,
	output scfr_pkg::result_t res
);
	import scfr_pkg::*;

	logic       holding_q, holding_d;
	logic [5:0] position_q, position_d;
	logic [5:0] bytes_left_q, bytes_left_d;
	logic [7:0] held_type_q, held_type_d;
	logic [7:0] held_length_q, held_length_d;
	logic [7:0] crc_q, crc_d;

	logic [7:0] b;
	logic [7:0] crc_base;
	logic [7:0] crc_next;
	logic       is_frame_code;
	logic       len_too_long;

	assign b = item.rx_byte;
	// crc unit input: a fresh frame starts from the init value
	assign crc_base = (position_q == 6'd0) ? CRC_INIT : crc_q;
	assign crc_next = crc8_step(crc_base, b, cfg.crc_poly);
	assign is_frame_code = (b == cfg.code_boot) || (b == cfg.code_erase) ||
		(b == cfg.code_write) || (b == cfg.code_get_page);
	assign len_too_long = ({1'b0, b} + LEN_SLACK) >= LEN_LIMIT;

	always_comb begin
		holding_d     = holding_q;
		position_d    = position_q;
		bytes_left_d  = bytes_left_q;
		held_type_d   = held_type_q;
		held_length_d = held_length_q;
		crc_d         = crc_q;
		res.event_res     = EV_NONE;
		res.payload_valid = 1'b0;
		res.payload_index = 6'd0;
		res.payload_byte  = 8'd0;

		if (item.op) begin
			holding_d = 1'b0;
		end else if (!holding_q) begin
			priority if (position_q == 6'd0) begin
				held_type_d = b;
				priority if (is_frame_code) begin
					crc_d        = crc_next;
					bytes_left_d = 6'd1;
					position_d   = 6'd1;
				end else if (b == cfg.code_probe) begin
					res.event_res = EV_WAITING;
				end else if (b == cfg.code_enter_loader) begin
					res.event_res = EV_READY;
					holding_d     = 1'b1;
				end else begin
				end
			end else if (position_q == 6'd1) begin
				held_length_d = b;
				priority if (held_type_q == cfg.code_boot) begin
					holding_d     = 1'b1;
					res.event_res = EV_COMPLETE;
					position_d    = 6'd0;
					bytes_left_d  = 6'd0;
					crc_d         = CRC_INIT;
				end else if (len_too_long) begin
					res.event_res = EV_BAD_CRC;
					position_d    = 6'd0;
					bytes_left_d  = 6'd0;
					crc_d         = CRC_INIT;
				end else begin
					crc_d        = crc_next;
					// length plus the checksum byte, known to stay below 64
					bytes_left_d = b[5:0] + 6'd1;
					position_d   = 6'd2;
				end
			end else begin
				if (bytes_left_q > 6'd1) begin
					bytes_left_d      = bytes_left_q - 6'd1;
					res.payload_valid = 1'b1;
					res.payload_index = position_q - HEADER_BYTES;
					res.payload_byte  = b;
					crc_d             = crc_next;
					position_d        = position_q + 6'd1;
				end else begin
					if (crc_q == b) begin
						holding_d     = 1'b1;
						res.event_res = EV_COMPLETE;
					end else begin
						res.event_res = EV_BAD_CRC;
					end
					position_d   = 6'd0;
					bytes_left_d = 6'd0;
					crc_d        = CRC_INIT;
				end
			end
		end

		res.frame_type   = held_type_d;
		res.frame_length = held_length_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q     <= 1'b0;
			position_q    <= 6'd0;
			bytes_left_q  <= 6'd0;
			held_type_q   <= 8'd0;
			held_length_q <= 8'd0;
			crc_q         <= CRC_INIT;
		end else if (en) begin
			holding_q     <= holding_d;
			position_q    <= position_d;
			bytes_left_q  <= bytes_left_d;
			held_type_q   <= held_type_d;
			held_length_q <= held_length_d;
			crc_q         <= crc_d;
		end
	end

	// between frames the crc and count sit at their idle values
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(position_q == 6'd0) |-> (crc_q == CRC_INIT && bytes_left_q == 6'd0))
		else $error("idle position with stale crc or count");

	a_hold_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		holding_q |-> (position_q == 6'd0))
		else $error("holding in the middle of a frame");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(position_q >= 6'd2) |-> (bytes_left_q != 6'd0))
		else $error("payload position with empty count");

endmodule

// ----- sv/serial_command_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// serial_command_frame_receiver
// Parses [type, length, payload, crc8] frames from received words.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while results are taken; the path from the
//   input register through the unrolled crc8 step and parser logic to the
//   result register sets it
// reset: parser state cleared, crc at 0xff, registers at their default codes,
//   both pipeline stages empty
module serial_command_frame_receiver (
	input logic        clk,
	input logic        arst_n,
	scfr_in_if.sink    rx,
	scfr_out_if.source res,
	scfr_cfg_if.sink   cfg
);
	import scfr_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;
	logic     valid_s2;
	result_t  result_s2;
	result_t  fsm_res;
	cfg_t     cfg_regs;
	logic     advance;

	assign advance  = valid_s1 && (!valid_s2 || res.ready);
	assign rx.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	scfr_cfg_regs u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg.valid && cfg.ready),
		.index (cfg.index),
		.data  (cfg.data),
		.cfg   (cfg_regs)
	);

	scfr_frame_fsm u_fsm (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.item  (item_s1),
		.cfg   (cfg_regs),
		.res   (fsm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1.op      <= rx.op;
			item_s1.rx_byte <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= fsm_res;
		end
	end

	assign res.valid         = valid_s2;
	assign res.event_res     = result_s2.event_res;
	assign res.frame_type    = result_s2.frame_type;
	assign res.frame_length  = result_s2.frame_length;
	assign res.payload_valid = result_s2.payload_valid;
	assign res.payload_index = result_s2.payload_index;
	assign res.payload_byte  = result_s2.payload_byte;

	a_word_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready) |=> valid_s1)
		else $error("accepted word not held in input stage");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res.valid)
		else $error("parsed word produced no result");

	a_payload_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.payload_valid) |-> (res.event_res == EV_NONE))
		else $error("payload word carries an event");

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// serial_command_frame_receiver testbench
// Feeds received words and release requests into the frame receiver,
// rebuilds the parser state and crc8 on the side, and compares every reply
// field against that model, across several code and polynomial settings.
// ----------------------------------------------------------------------------
import scfr_pkg::*;

typedef enum logic {
	OP_BYTE    = 1'b0,
	OP_RELEASE = 1'b1
} word_op_t;

class frame_checker;
	logic [7:0] regs [7];
	bit         holding;
	bit   [5:0] position;
	bit   [5:0] bytes_left;
	bit   [7:0] held_type;
	bit   [7:0] held_length;
	bit   [7:0] running_crc;
	result_t    pending_replies[$];
	int         mismatches;
	int         replies_seen;
	int         payload_seen;
	int         event_count [5];

	function new();
		regs[REG_CRC_POLY]     = RST_CRC_POLY;
		regs[REG_CODE_BOOT]    = RST_CODE_BOOT;
		regs[REG_CODE_ERASE]   = RST_CODE_ERASE;
		regs[REG_CODE_WRITE]   = RST_CODE_WRITE;
		regs[REG_CODE_GETPAGE] = RST_CODE_GETPAGE;
		regs[REG_CODE_PROBE]   = RST_CODE_PROBE;
		regs[REG_CODE_LOADER]  = RST_CODE_LOADER;
		holding     = 1'b0;
		held_type   = 8'h00;
		held_length = 8'h00;
		frame_restart();
	endfunction

	function void frame_restart();
		position    = 6'd0;
		bytes_left  = 6'd0;
		running_crc = 8'hFF;
	endfunction

	function void write_reg(reg_idx_t idx, logic [7:0] v);
		regs[idx] = v;
	endfunction

	function logic [7:0] crc_update(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		repeat (8) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ regs[REG_CRC_POLY]) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function int pending();
		return pending_replies.size();
	endfunction

	// work out the reply to one accepted word and queue it
	function void accept_word(logic op, logic [7:0] b);
		result_t r;
		r.event_res     = EV_NONE;
		r.payload_valid = 1'b0;
		r.payload_index = 6'd0;
		r.payload_byte  = 8'h00;
		if (op == OP_RELEASE) begin
			holding = 1'b0;
		end else if (!holding) begin
			if (position == 6'd0) begin
				held_type = b;
				if (b == regs[REG_CODE_BOOT] || b == regs[REG_CODE_ERASE] ||
						b == regs[REG_CODE_WRITE] || b == regs[REG_CODE_GETPAGE]) begin
					running_crc = crc_update(8'hFF, b);
					bytes_left  = 6'd1;
					position    = 6'd1;
				end else if (b == regs[REG_CODE_PROBE]) begin
					r.event_res = EV_WAITING;
				end else if (b == regs[REG_CODE_LOADER]) begin
					r.event_res = EV_READY;
					holding     = 1'b1;
				end
			end else if (position == 6'd1) begin
				held_length = b;
				if (held_type == regs[REG_CODE_BOOT]) begin
					holding     = 1'b1;
					r.event_res = EV_COMPLETE;
					frame_restart();
				end else if (int'(b) + 4 >= BUFFER_BYTES) begin
					r.event_res = EV_BAD_CRC;
					frame_restart();
				end else begin
					running_crc = crc_update(running_crc, b);
					bytes_left  = 6'(b + 8'd1);
					position    = 6'd2;
				end
			end else if (bytes_left > 6'd1) begin
				bytes_left      = bytes_left - 6'd1;
				r.payload_valid = 1'b1;
				r.payload_index = position - 6'd2;
				r.payload_byte  = b;
				running_crc     = crc_update(running_crc, b);
				position        = position + 6'd1;
			end else begin
				// last word of the frame is the checksum
				if (running_crc == b) begin
					holding     = 1'b1;
					r.event_res = EV_COMPLETE;
				end else begin
					r.event_res = EV_BAD_CRC;
				end
				frame_restart();
			end
		end
		r.frame_type   = held_type;
		r.frame_length = held_length;
		pending_replies.push_back(r);
	endfunction

	function void match_reply(result_t got);
		result_t want;
		replies_seen++;
		if (pending_replies.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("reply with no word outstanding: ev=%0d type=%02h len=%02h",
					got.event_res, got.frame_type, got.frame_length);
			return;
		end
		want = pending_replies.pop_front();
		if (int'(want.event_res) < 5)
			event_count[want.event_res]++;
		if (want.payload_valid)
			payload_seen++;
		if (got.event_res !== want.event_res || got.frame_type !== want.frame_type ||
				got.frame_length !== want.frame_length ||
				got.payload_valid !== want.payload_valid ||
				got.payload_index !== want.payload_index ||
				got.payload_byte !== want.payload_byte) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("reply %0d mismatch", replies_seen);
				$display("  expected ev=%0d type=%02h len=%02h pv=%0d idx=%0d byte=%02h",
					want.event_res, want.frame_type, want.frame_length,
					want.payload_valid, want.payload_index, want.payload_byte);
				$display("  actual   ev=%0d type=%02h len=%02h pv=%0d idx=%0d byte=%02h",
					got.event_res, got.frame_type, got.frame_length,
					got.payload_valid, got.payload_index, got.payload_byte);
			end
		end
	endfunction
endclass

module testbench;
	localparam int LONG_STALL  = 300;
	localparam int QUIET_LIMIT = 5000;

	logic clk;
	logic arst_n;

	scfr_in_if  rx_ch();
	scfr_out_if res_ch();
	scfr_cfg_if cfg_ch();

	serial_command_frame_receiver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	frame_checker sb = new();

	bit long_stall_req;
	int long_stalls;
	int burst_left;
	int words_sent;
	int counted_words;
	int reg_writes;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver side: changing ready patterns, plus a long hold-off on request
	initial begin
		int seg_left;
		int mode;
		seg_left = 0;
		mode     = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				res_ch.ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				long_stall_req = 1'b0;
				long_stalls++;
			end else begin
				if (seg_left == 0) begin
					mode     = $urandom_range(0, 3);
					seg_left = $urandom_range(10, 80);
				end
				seg_left--;
				case (mode)
					0: begin
						res_ch.ready <= 1'b1;
					end
					1: begin
						res_ch.ready <= 1'($urandom_range(0, 1));
					end
					2: begin
						res_ch.ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						res_ch.ready <= (seg_left % 3 != 0);
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.event_res     = event_t'(res_ch.event_res);
			got.frame_type    = res_ch.frame_type;
			got.frame_length  = res_ch.frame_length;
			got.payload_valid = res_ch.payload_valid;
			got.payload_index = res_ch.payload_index;
			got.payload_byte  = res_ch.payload_byte;
			sb.match_reply(got);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
		$display("testbench NOT OK");
		$finish;
	end

	task automatic idle_in(input int n);
		if (n > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// one word on the input channel; valid stays up for a following word
	task automatic send_word(input word_op_t op, input logic [7:0] b);
		if (burst_left == 0) begin
			idle_in(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		rx_ch.valid   <= 1'b1;
		rx_ch.op      <= op;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		// words dropped while held do not count toward the phase size
		if (!(op == OP_BYTE && sb.holding))
			counted_words++;
		words_sent++;
		sb.accept_word(op, b);
	endtask

	task automatic send_frame(input logic [7:0] typ, input int len, input bit good);
		logic [7:0] crc;
		logic [7:0] b;
		crc = sb.crc_update(8'hFF, typ);
		send_word(OP_BYTE, typ);
		crc = sb.crc_update(crc, 8'(len));
		send_word(OP_BYTE, 8'(len));
		for (int i = 0; i < len; i++) begin
			b   = 8'($urandom);
			crc = sb.crc_update(crc, b);
			send_word(OP_BYTE, b);
		end
		if (!good)
			crc = crc ^ 8'($urandom_range(1, 255));
		send_word(OP_BYTE, crc);
	endtask

	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] poly, input logic [7:0] boot,
			input logic [7:0] erase, input logic [7:0] wr, input logic [7:0] getpage,
			input logic [7:0] probe, input logic [7:0] loader);
		logic [7:0] v [7];
		v = '{poly, boot, erase, wr, getpage, probe, loader};
		for (int i = 0; i < 7; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= reg_idx_t'(i);
			cfg_ch.data  <= v[i];
			do @(posedge clk); while (!cfg_ch.ready);
			sb.write_reg(reg_idx_t'(i), v[i]);
			reg_writes++;
		end
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_frame_type();
		case ($urandom_range(0, 2))
			0: return sb.regs[REG_CODE_ERASE];
			1: return sb.regs[REG_CODE_WRITE];
			default: return sb.regs[REG_CODE_GETPAGE];
		endcase
	endfunction

	// mostly short payloads, a few at the buffer limit
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 6);
		else if (r < 97)
			return $urandom_range(7, 34);
		return 35;
	endfunction

	task automatic run_random(input int target);
		int start;
		int pick;
		int len;
		start = counted_words;
		while (counted_words - start < target) begin
			pick = $urandom_range(0, 99);
			if (sb.holding) begin
				if (pick < 80)
					send_word(OP_RELEASE, 8'($urandom));
				else
					send_word(OP_BYTE, 8'($urandom));
			end else if (pick < 40) begin
				send_frame(pick_frame_type(), pick_len(), 1'b1);
			end else if (pick < 50) begin
				send_frame(pick_frame_type(), pick_len(), 1'b0);
			end else if (pick < 58) begin
				send_word(OP_BYTE, sb.regs[REG_CODE_BOOT]);
				send_word(OP_BYTE, 8'($urandom));
			end else if (pick < 63) begin
				send_word(OP_BYTE, sb.regs[REG_CODE_PROBE]);
			end else if (pick < 68) begin
				send_word(OP_BYTE, sb.regs[REG_CODE_LOADER]);
			end else if (pick < 74) begin
				send_word(OP_BYTE, pick_frame_type());
				send_word(OP_BYTE, 8'($urandom_range(36, 255)));
			end else if (pick < 82) begin
				// frame cut short, later words fall into its payload and checksum
				len = pick_len();
				send_word(OP_BYTE, pick_frame_type());
				send_word(OP_BYTE, 8'(len));
				repeat ($urandom_range(0, len)) send_word(OP_BYTE, 8'($urandom));
			end else if (pick < 92) begin
				send_word(OP_BYTE, 8'($urandom));
			end else begin
				send_word(OP_RELEASE, 8'($urandom));
			end
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		rx_ch.valid   <= 1'b0;
		rx_ch.op      <= OP_BYTE;
		rx_ch.rx_byte <= 8'h00;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.index  <= REG_CRC_POLY;
		cfg_ch.data   <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed words at the default codes
		send_word(OP_BYTE, 8'h00);
		send_word(OP_BYTE, 8'hFF);
		send_word(OP_BYTE, RST_CODE_PROBE);
		send_word(OP_RELEASE, 8'hA5);
		send_word(OP_BYTE, RST_CODE_LOADER);
		send_word(OP_BYTE, RST_CODE_WRITE);
		send_word(OP_RELEASE, 8'h5A);
		send_word(OP_BYTE, RST_CODE_BOOT);
		send_word(OP_BYTE, 8'hFF);
		send_word(OP_RELEASE, 8'hFF);
		send_frame(RST_CODE_ERASE, 0, 1'b1);
		send_word(OP_RELEASE, 8'h00);
		send_frame(RST_CODE_GETPAGE, 2, 1'b0);
		send_word(OP_BYTE, RST_CODE_WRITE);
		send_word(OP_BYTE, 8'd36);
		send_word(OP_BYTE, RST_CODE_WRITE);
		send_word(OP_BYTE, 8'hFF);
		run_random(110);

		wait_drained();
		program_regs(8'h00, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h7E, 8'h81);
		long_stall_req = 1'b1;
		run_random(120);

		wait_drained();
		program_regs(8'hFF, 8'hFF, 8'h00, 8'h01, 8'h80, 8'hFE, 8'h7F);
		run_random(120);

		// overlapping codes: frame codes shadow each other, probe shadows loader
		wait_drained();
		program_regs(8'h07, 8'h20, 8'h21, 8'h21, 8'h22, 8'h24, 8'h24);
		run_random(120);

		wait_drained();
		program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
		if (sb.holding)
			send_word(OP_RELEASE, 8'h3C);
		send_frame(sb.regs[REG_CODE_WRITE], 35, 1'b1);
		run_random(120);

		wait_drained();
		repeat (8) @(posedge clk);

		$display("%0d words sent, %0d replies checked, %0d register writes, %0d long stalls",
			words_sent, sb.replies_seen, reg_writes, long_stalls);
		$display("complete %0d, bad crc %0d, waiting %0d, ready %0d, payload words %0d",
			sb.event_count[EV_COMPLETE], sb.event_count[EV_BAD_CRC],
			sb.event_count[EV_WAITING], sb.event_count[EV_READY], sb.payload_seen);
		if (sb.mismatches > 10)
			$display("%0d mismatches in total", sb.mismatches);
		if (sb.pending() != 0)
			$display("%0d replies never arrived", sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
